// ----- hw/rtl/lzrb_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS ring buffer decoder package
// Shared constants, word types and the window access request.
// ----------------------------------------------------------------------------
package lzrb_pkg;

    localparam int POS_W       = 12;
    localparam int WINDOW_DEF  = 4096;
    localparam int COUNT_W     = 24;
    localparam int LEN_W       = 5;
    localparam int FILL_W      = POS_W + 1;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [POS_W-1:0]   START_POS  = 12'hFEE;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;
    localparam logic [LEN_W-1:0]   MIN_MATCH  = 5'd3;
    localparam logic [3:0]         FLAG_COUNT = 4'd8;
    localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(1) << POS_W;

    // Register index of the configuration port.
    localparam logic [APB_ADDR_W-3:0] REG_EXPANDED_LENGTH = '0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } out_word_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [POS_W-1:0] raddr;
    } mem_req_t;

endpackage

// ----- hw/rtl/lzrb_window.sv -----
// ----------------------------------------------------------------------------
// LZSS window memory
// Ring window with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lzrb_window import lzrb_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_DEF
) (
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rd_data
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] rd_data_reg;

    // A read of the entry written in the same cycle returns the old value;
    // the controller forwards the new one itself.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/lzrb_regs.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder configuration registers
// APB-style register file holding the expanded length.
// ----------------------------------------------------------------------------
module lzrb_regs import lzrb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    expanded_length
);

    logic [COUNT_W-1:0]      length_reg;
    logic [APB_ADDR_W-3:0]   reg_index;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_index == REG_EXPANDED_LENGTH)
        begin
            length_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_EXPANDED_LENGTH)
        begin
            prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, length_reg};
        end
    end

    assign expanded_length = length_reg;

endmodule

// ----- hw/rtl/lzrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder control
// Parses flag, literal and match bytes, drives the window and the output word.
// ----------------------------------------------------------------------------
module lzrb_ctrl import lzrb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] expanded_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_data,
    output mem_req_t           mem_req,
    input  logic [7:0]         rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_LIT, S_COPY} state_t;
    typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_HIGH} phase_t;

    state_t             state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic               start_reg, start_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [3:0]         flags_left_reg, flags_left_next;
    logic [7:0]         match_low_reg, match_low_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [POS_W-1:0]   wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]   rp_reg, rp_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic               fwd_reg, fwd_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic               emit_ok;
    logic [COUNT_W-1:0] count_inc;
    logic [FILL_W-1:0]  fill_inc;
    logic [7:0]         nf_bits;
    logic [3:0]         nf_left;
    phase_t             nf_phase;
    logic [7:0]         copy_data;
    logic [POS_W-1:0]   src_pos;
    logic [POS_W-1:0]   src_off;
    logic [POS_W-1:0]   rp_off;
    logic [COUNT_W-1:0] cur_count;
    phase_t             cur_phase;

    assign emit_ok   = !out_valid_reg || out_ready;
    assign count_inc = (out_count_reg == COUNT_MAX) ? out_count_reg : out_count_reg + 1'b1;
    assign fill_inc  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
    assign nf_bits   = flag_bits_reg >> 1;
    assign nf_left   = (flags_left_reg == 4'd0) ? 4'd0 : flags_left_reg - 4'd1;
    assign nf_phase  = (nf_left == 4'd0) ? PH_FLAG : PH_ITEM;
    assign src_pos   = {byte_reg[7:4], match_low_reg};
    // Entries are written in order from the start position, so an entry
    // holds stream data only if its offset from there is below the fill count.
    assign src_off   = src_pos - START_POS;
    assign rp_off    = rp_reg - START_POS;
    assign copy_data = fwd_reg ? fwd_data_reg : (hit_reg ? rd_data : 8'd0);

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        start_next      = start_reg;
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        match_low_next  = match_low_reg;
        out_count_next  = out_count_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        rp_next         = rp_reg;
        remain_next     = remain_reg;
        fwd_next        = fwd_reg;
        fwd_data_next   = fwd_data_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        mem_req         = '0;
        cur_count       = out_count_reg;
        cur_phase       = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_data.in_byte;
                    start_next = in_data.start_of_stream;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (start_reg)
                begin
                    phase_next      = PH_FLAG;
                    flag_bits_next  = 8'd0;
                    flags_left_next = 4'd0;
                    match_low_next  = 8'd0;
                    out_count_next  = '0;
                    wp_next         = START_POS;
                    fill_next       = '0;
                    cur_count       = '0;
                    cur_phase       = PH_FLAG;
                end
                if (cur_count < expanded_length)
                begin
                    case (cur_phase)
                        PH_ITEM:
                        begin
                            if (flag_bits_reg[0])
                            begin
                                state_next = S_LIT;
                            end
                            else
                            begin
                                match_low_next = byte_reg;
                                phase_next     = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = src_pos;
                            hit_next      = {1'b0, src_off} < fill_reg;
                            fwd_next      = 1'b0;
                            rp_next       = src_pos + 1'b1;
                            remain_next   = {1'b0, byte_reg[3:0]} + MIN_MATCH;
                            state_next    = S_COPY;
                        end
                        default:
                        begin
                            flag_bits_next  = byte_reg;
                            flags_left_next = FLAG_COUNT;
                            phase_next      = PH_ITEM;
                        end
                    endcase
                end
            end
            S_LIT:
            begin
                if (emit_ok)
                begin
                    mem_req.we                = 1'b1;
                    mem_req.waddr             = wp_reg;
                    mem_req.wdata             = byte_reg;
                    out_valid_next            = 1'b1;
                    out_word_next.out_byte    = byte_reg;
                    out_word_next.last_of_run = 1'b1;
                    out_word_next.stream_done = count_inc >= expanded_length;
                    out_count_next            = count_inc;
                    wp_next                   = wp_reg + 1'b1;
                    fill_next                 = fill_inc;
                    flag_bits_next            = nf_bits;
                    flags_left_next           = nf_left;
                    phase_next                = nf_phase;
                    state_next                = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (emit_ok)
                begin
                    mem_req.we                = 1'b1;
                    mem_req.waddr             = wp_reg;
                    mem_req.wdata             = copy_data;
                    out_valid_next            = 1'b1;
                    out_word_next.out_byte    = copy_data;
                    out_word_next.last_of_run = remain_reg == LEN_W'(1);
                    out_word_next.stream_done = count_inc >= expanded_length;
                    out_count_next            = count_inc;
                    wp_next                   = wp_reg + 1'b1;
                    fill_next                 = fill_inc;
                    remain_next               = remain_reg - 1'b1;
                    if (remain_reg != LEN_W'(1))
                    begin
                        // A source one behind the write position reads the
                        // byte being written now: take it straight across.
                        mem_req.re    = 1'b1;
                        mem_req.raddr = rp_reg;
                        fwd_next      = rp_reg == wp_reg;
                        fwd_data_next = copy_data;
                        hit_next      = {1'b0, rp_off} < fill_reg;
                        rp_next       = rp_reg + 1'b1;
                    end
                    else
                    begin
                        flag_bits_next  = nf_bits;
                        flags_left_next = nf_left;
                        phase_next      = nf_phase;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            match_low_reg  <= 8'd0;
            out_count_reg  <= '0;
            wp_reg         <= START_POS;
            fill_reg       <= '0;
            remain_reg     <= '0;
            fwd_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            match_low_reg  <= match_low_next;
            out_count_reg  <= out_count_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            remain_reg     <= remain_next;
            fwd_reg        <= fwd_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        rp_reg       <= rp_next;
        fwd_data_reg <= fwd_data_next;
        out_word_reg <= out_word_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// ----- hw/rtl/lzss_ring_buffer_decoder.sv -----
// ----------------------------------------------------------------------------
// LZSS ring buffer decoder
// Decodes an LZSS stream with a 4096-byte ring window, one output word per
// cycle while a match is copied and the output is not stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  in        input      in_byte, start_of_stream
//  out       output     out_byte, last_of_run, stream_done
//  apb       config     expanded_length at byte address 0
//
//  Flag and match low bytes pass idle and decode; a literal then the literal
//  state, a match high byte the copy state once per byte. The window does one
//  read and one write per cycle, so a match copies one byte per cycle.
//  The window needs no clearing pass after reset or stream start: a fill
//  count marks which entries hold stream data, all others read as zero.
//  A stalled output word holds the copy; the next input word is taken as soon
//  as the previous one is fully decoded, even while its last output waits.
// ----------------------------------------------------------------------------
module lzss_ring_buffer_decoder import lzrb_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0] expanded_length;
    mem_req_t           mem_req;
    logic [7:0]         rd_data;

    lzrb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .expanded_length (expanded_length)
    );

    lzrb_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    lzrb_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .expanded_length (expanded_length),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mem_req         (mem_req),
        .rd_data         (rd_data)
    );

    // Every window write loads an output word.
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |=> out_valid)
        else $error("window write without an output word");

    // A window write never overwrites an output word still waiting.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (!out_valid || out_ready))
        else $error("window write while output word is stalled");

    // No window access happens in the cycle an input word is taken.
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!mem_req.we && !mem_req.re))
        else $error("window access during input accept");

endmodule
